@@ rtl/des_block_cipher_top_defines.svh @@
// assertion macros for the des block cipher
`ifndef DES_BLOCK_CIPHER_TOP_DEFINES_SVH
`define DES_BLOCK_CIPHER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define DESBC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("desbc same-cycle check failed");
`define DESBC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("desbc next-cycle check failed");
`else
`define DESBC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define DESBC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/desbc_pkg.sv @@
// des block cipher package: mode codes, command struct, permutation and s-box functions
`timescale 1ns / 1ps
package desbc_pkg;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_ENC  = 2'd1;
  localparam logic [1:0] MODE_DEC  = 2'd2;

  typedef struct packed {
    logic       key_we;
    logic [3:0] key_rd_addr;
    logic       load_block;
    logic       do_round;
    logic       load_out;
  } desbc_cmd_t;

  localparam logic [7:0] TAB_IP [64] = '{
    8'd58, 8'd50, 8'd42, 8'd34, 8'd26, 8'd18, 8'd10, 8'd2,
    8'd60, 8'd52, 8'd44, 8'd36, 8'd28, 8'd20, 8'd12, 8'd4,
    8'd62, 8'd54, 8'd46, 8'd38, 8'd30, 8'd22, 8'd14, 8'd6,
    8'd64, 8'd56, 8'd48, 8'd40, 8'd32, 8'd24, 8'd16, 8'd8,
    8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9,  8'd1,
    8'd59, 8'd51, 8'd43, 8'd35, 8'd27, 8'd19, 8'd11, 8'd3,
    8'd61, 8'd53, 8'd45, 8'd37, 8'd29, 8'd21, 8'd13, 8'd5,
    8'd63, 8'd55, 8'd47, 8'd39, 8'd31, 8'd23, 8'd15, 8'd7
  };

  localparam logic [7:0] TAB_FP [64] = '{
    8'd40, 8'd8, 8'd48, 8'd16, 8'd56, 8'd24, 8'd64, 8'd32,
    8'd39, 8'd7, 8'd47, 8'd15, 8'd55, 8'd23, 8'd63, 8'd31,
    8'd38, 8'd6, 8'd46, 8'd14, 8'd54, 8'd22, 8'd62, 8'd30,
    8'd37, 8'd5, 8'd45, 8'd13, 8'd53, 8'd21, 8'd61, 8'd29,
    8'd36, 8'd4, 8'd44, 8'd12, 8'd52, 8'd20, 8'd60, 8'd28,
    8'd35, 8'd3, 8'd43, 8'd11, 8'd51, 8'd19, 8'd59, 8'd27,
    8'd34, 8'd2, 8'd42, 8'd10, 8'd50, 8'd18, 8'd58, 8'd26,
    8'd33, 8'd1, 8'd41, 8'd9,  8'd49, 8'd17, 8'd57, 8'd25
  };

  localparam logic [7:0] TAB_E [48] = '{
    8'd32, 8'd1,  8'd2,  8'd3,  8'd4,  8'd5,  8'd4,  8'd5,  8'd6,  8'd7,  8'd8,  8'd9,
    8'd8,  8'd9,  8'd10, 8'd11, 8'd12, 8'd13, 8'd12, 8'd13, 8'd14, 8'd15, 8'd16, 8'd17,
    8'd16, 8'd17, 8'd18, 8'd19, 8'd20, 8'd21, 8'd20, 8'd21, 8'd22, 8'd23, 8'd24, 8'd25,
    8'd24, 8'd25, 8'd26, 8'd27, 8'd28, 8'd29, 8'd28, 8'd29, 8'd30, 8'd31, 8'd32, 8'd1
  };

  localparam logic [7:0] TAB_P [32] = '{
    8'd16, 8'd7,  8'd20, 8'd21, 8'd29, 8'd12, 8'd28, 8'd17,
    8'd1,  8'd15, 8'd23, 8'd26, 8'd5,  8'd18, 8'd31, 8'd10,
    8'd2,  8'd8,  8'd24, 8'd14, 8'd32, 8'd27, 8'd3,  8'd9,
    8'd19, 8'd13, 8'd30, 8'd6,  8'd22, 8'd11, 8'd4,  8'd25
  };

  localparam logic [3:0] TAB_S [8][64] = '{
    '{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
      4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7,
      4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1,
      4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8,
      4'd4, 4'd1, 4'd14, 4'd8, 4'd13, 4'd6, 4'd2, 4'd11,
      4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0,
      4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7,
      4'd5, 4'd11, 4'd3, 4'd14, 4'd10, 4'd0, 4'd6, 4'd13},
    '{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4,
      4'd9, 4'd7, 4'd2, 4'd13, 4'd12, 4'd0, 4'd5, 4'd10,
      4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14,
      4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5,
      4'd0, 4'd14, 4'd7, 4'd11, 4'd10, 4'd4, 4'd13, 4'd1,
      4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15,
      4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2,
      4'd11, 4'd6, 4'd7, 4'd12, 4'd0, 4'd5, 4'd14, 4'd9},
    '{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5,
      4'd1, 4'd13, 4'd12, 4'd7, 4'd11, 4'd4, 4'd2, 4'd8,
      4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10,
      4'd2, 4'd8, 4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
      4'd13, 4'd6, 4'd4, 4'd9, 4'd8, 4'd15, 4'd3, 4'd0,
      4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7,
      4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7,
      4'd4, 4'd15, 4'd14, 4'd3, 4'd11, 4'd5, 4'd2, 4'd12},
    '{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10,
      4'd1, 4'd2, 4'd8, 4'd5, 4'd11, 4'd12, 4'd4, 4'd15,
      4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3,
      4'd4, 4'd7, 4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9,
      4'd10, 4'd6, 4'd9, 4'd0, 4'd12, 4'd11, 4'd7, 4'd13,
      4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4,
      4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8,
      4'd9, 4'd4, 4'd5, 4'd11, 4'd12, 4'd7, 4'd2, 4'd14},
    '{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6,
      4'd8, 4'd5, 4'd3, 4'd15, 4'd13, 4'd0, 4'd14, 4'd9,
      4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1,
      4'd5, 4'd0, 4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6,
      4'd4, 4'd2, 4'd1, 4'd11, 4'd10, 4'd13, 4'd7, 4'd8,
      4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14,
      4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13,
      4'd6, 4'd15, 4'd0, 4'd9, 4'd10, 4'd4, 4'd5, 4'd3},
    '{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8,
      4'd0, 4'd13, 4'd3, 4'd4, 4'd14, 4'd7, 4'd5, 4'd11,
      4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5,
      4'd6, 4'd1, 4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8,
      4'd9, 4'd14, 4'd15, 4'd5, 4'd2, 4'd8, 4'd12, 4'd3,
      4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6,
      4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10,
      4'd11, 4'd14, 4'd1, 4'd7, 4'd6, 4'd0, 4'd8, 4'd13},
    '{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13,
      4'd3, 4'd12, 4'd9, 4'd7, 4'd5, 4'd10, 4'd6, 4'd1,
      4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10,
      4'd14, 4'd3, 4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6,
      4'd1, 4'd4, 4'd11, 4'd13, 4'd12, 4'd3, 4'd7, 4'd14,
      4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2,
      4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7,
      4'd9, 4'd5, 4'd0, 4'd15, 4'd14, 4'd2, 4'd3, 4'd12},
    '{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1,
      4'd10, 4'd9, 4'd3, 4'd14, 4'd5, 4'd0, 4'd12, 4'd7,
      4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4,
      4'd12, 4'd5, 4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2,
      4'd7, 4'd11, 4'd4, 4'd1, 4'd9, 4'd12, 4'd14, 4'd2,
      4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8,
      4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13,
      4'd15, 4'd12, 4'd9, 4'd0, 4'd3, 4'd5, 4'd6, 4'd11}
  };

  // table entry n gives the source bit of output bit n; bits are counted from the msb, starting at one
  function automatic logic [63:0] perm_ip(input logic [63:0] src);
    logic [63:0] res;
    for (int i = 0; i < 64; i++) begin
      res[63-i] = src[64-int'(TAB_IP[i])];
    end
    return res;
  endfunction

  function automatic logic [63:0] perm_fp(input logic [63:0] src);
    logic [63:0] res;
    for (int i = 0; i < 64; i++) begin
      res[63-i] = src[64-int'(TAB_FP[i])];
    end
    return res;
  endfunction

  function automatic logic [47:0] expand_e(input logic [31:0] src);
    logic [47:0] res;
    for (int i = 0; i < 48; i++) begin
      res[47-i] = src[32-int'(TAB_E[i])];
    end
    return res;
  endfunction

  function automatic logic [31:0] perm_p(input logic [31:0] src);
    logic [31:0] res;
    for (int i = 0; i < 32; i++) begin
      res[31-i] = src[32-int'(TAB_P[i])];
    end
    return res;
  endfunction

  function automatic logic [31:0] feistel_f(input logic [31:0] half, input logic [47:0] key);
    logic [47:0] x;
    logic [5:0]  six;
    logic [31:0] s_out;
    x = expand_e(half) ^ key;
    for (int b = 0; b < 8; b++) begin
      six = x[47-6*b -: 6];
      // row from the outer bits, column from the inner four
      s_out[31-4*b -: 4] = TAB_S[b][{six[5], six[0], six[4:1]}];
    end
    return perm_p(s_out);
  endfunction

endpackage

@@ rtl/desbc_ctrl.sv @@
// des block cipher controller: item decode and round sequencing
`timescale 1ns / 1ps
module desbc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [1:0]            in_mode_i,
  output logic                  in_ready_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output desbc_pkg::desbc_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ROUND  = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state_q, state_d;
  logic [3:0] rnd_q, rnd_d;
  logic       dec_q, dec_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    rnd_d      = rnd_q;
    dec_d      = dec_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        // first key: entry 0 for encrypt, entry 15 for decrypt
        cmd_o.key_rd_addr = {4{in_mode_i == desbc_pkg::MODE_DEC}};
        // ready is high throughout idle, so valid alone marks a transfer
        if (in_valid_i) begin
          case (in_mode_i)
            desbc_pkg::MODE_LOAD: begin
              cmd_o.key_we = 1'b1;
            end
            desbc_pkg::MODE_ENC, desbc_pkg::MODE_DEC: begin
              cmd_o.load_block = 1'b1;
              dec_d   = (in_mode_i == desbc_pkg::MODE_DEC);
              rnd_d   = '0;
              state_d = ST_ROUND;
            end
            default: begin
            end
          endcase
        end
      end
      ST_ROUND: begin
        cmd_o.do_round    = 1'b1;
        rnd_d             = rnd_q + 4'd1;
        // prefetch the key of the following round
        cmd_o.key_rd_addr = rnd_d ^ {4{dec_q}};
        if (rnd_q == 4'hF) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rnd_q       <= '0;
      dec_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rnd_q       <= rnd_d;
      dec_q       <= dec_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ rtl/desbc_dp.sv @@
// des block cipher datapath: round key memory, feistel round and output register
`timescale 1ns / 1ps
module desbc_dp (
  input  logic                  clk_i,
  input  desbc_pkg::desbc_cmd_t cmd_i,
  input  logic [3:0]            key_index_i,
  input  logic [47:0]           round_key_i,
  input  logic [63:0]           block_in_i,
  output logic [63:0]           block_out_o
);

  logic [47:0] key_mem [16];
  logic [47:0] key_rd_q;
  logic [31:0] l_q;
  logic [31:0] r_q;
  logic [63:0] ip_val;
  logic [63:0] out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_we) begin
      key_mem[key_index_i] <= round_key_i;
    end
    key_rd_q <= key_mem[cmd_i.key_rd_addr];
  end

  assign ip_val = desbc_pkg::perm_ip(block_in_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_block) begin
      l_q <= ip_val[63:32];
      r_q <= ip_val[31:0];
    end else if (cmd_i.do_round) begin
      l_q <= r_q;
      r_q <= desbc_pkg::feistel_f(r_q, key_rd_q) ^ l_q;
    end
  end

  // halves swapped before the final permutation
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= desbc_pkg::perm_fp({r_q, l_q});
    end
  end

  assign block_out_o = out_q;

endmodule

@@ rtl/des_block_cipher_top.sv @@
// des block cipher top level: stream ports, controller and datapath
//
// Input stream: s_axis_tuser_i carries the item kind (load round key, encrypt,
// decrypt), s_axis_tdata_i the key index, round key and data block.
// A load transfer writes one entry of the sixteen-entry round key table and
// gives no output. Kind code 3 is dropped without effect.
// An encrypt or decrypt transfer runs sixteen feistel rounds, one per cycle,
// each using one round key read from the key memory (prefetched into a
// read register ahead of its round). Once a block is accepted, the sixteen
// rounds run, then the final permutation loads the output register; no new
// item is taken until the block has reached the output register.
// The result waits in an output register; the block accepts the next item
// while it waits, and only a second finished block stalls on a busy receiver.
// Reset clears the controller and output valid; the key table is not cleared
// and every entry a block uses must be loaded first.
`timescale 1ns / 1ps
`include "des_block_cipher_top_defines.svh"
module des_block_cipher_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [3:0] key_index, [51:4] round_key, [115:52] block_in, [119:116] zero
  input  logic [119:0] s_axis_tdata_i,
  // [1:0] mode
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [63:0] block_out
  output logic [63:0]  m_axis_tdata_o
);

  desbc_pkg::desbc_cmd_t cmd;
  logic                  s_acc;
  logic                  blk_acc;

  desbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_mode_i   (s_axis_tuser_i),
    .in_ready_o  (s_axis_tready_o),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .cmd_o       (cmd)
  );

  desbc_dp u_dp (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .key_index_i (s_axis_tdata_i[3:0]),
    .round_key_i (s_axis_tdata_i[51:4]),
    .block_in_i  (s_axis_tdata_i[115:52]),
    .block_out_o (m_axis_tdata_o)
  );

  assign s_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign blk_acc = s_acc && ((s_axis_tuser_i == desbc_pkg::MODE_ENC) ||
                             (s_axis_tuser_i == desbc_pkg::MODE_DEC));

  `DESBC_ASSERT_NEXT(a_block_starts_rounds, clk_i, rst_ni, blk_acc, cmd.do_round)
  `DESBC_ASSERT_IMP(a_no_accept_in_rounds, clk_i, rst_ni, cmd.do_round, !s_axis_tready_o)
  `DESBC_ASSERT_IMP(a_out_free_on_load, clk_i, rst_ni, cmd.load_out, !m_axis_tvalid_o || m_axis_tready_i)
  `DESBC_ASSERT_NEXT(a_load_gives_valid, clk_i, rst_ni, cmd.load_out, m_axis_tvalid_o)

endmodule
